// ----- sv/hsfe_pkg.sv -----
// ----------------------------------------------------------------------------
// hsfe_pkg
// Shared types, constants and the node table of the 20-node hexahedron
// shape function evaluator.
// ----------------------------------------------------------------------------
package hsfe_pkg;

  localparam int NODES  = 20;
  localparam int NODE_W = 5;

  // one component of a node's reference coordinate: -1, 0 or +1
  typedef logic signed [1:0] pos_t;

  localparam pos_t POS_NEG  = 2'sb11;
  localparam pos_t POS_ZERO = 2'sb00;
  localparam pos_t POS_PLUS = 2'sb01;

  // element [0] is csi, [1] eta, [2] zeta
  typedef pos_t [2:0] node_pos_t;

  // extra right shift of a rounded product on top of FRAC_BITS
  typedef enum logic [1:0] {
    SH_F  = 2'd0,
    SH_F1 = 2'd1,
    SH_F2 = 2'd2
  } shift_t;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  function automatic node_pos_t node_pos(input logic [NODE_W-1:0] n);
    node_pos_t p;
    unique case (n)
      5'd0:    p = '{POS_NEG,  POS_NEG,  POS_NEG};
      5'd1:    p = '{POS_NEG,  POS_NEG,  POS_PLUS};
      5'd2:    p = '{POS_NEG,  POS_PLUS, POS_PLUS};
      5'd3:    p = '{POS_NEG,  POS_PLUS, POS_NEG};
      5'd4:    p = '{POS_PLUS, POS_NEG,  POS_NEG};
      5'd5:    p = '{POS_PLUS, POS_NEG,  POS_PLUS};
      5'd6:    p = '{POS_PLUS, POS_PLUS, POS_PLUS};
      5'd7:    p = '{POS_PLUS, POS_PLUS, POS_NEG};
      5'd8:    p = '{POS_NEG,  POS_NEG,  POS_ZERO};
      5'd9:    p = '{POS_NEG,  POS_ZERO, POS_NEG};
      5'd10:   p = '{POS_ZERO, POS_NEG,  POS_NEG};
      5'd11:   p = '{POS_NEG,  POS_ZERO, POS_PLUS};
      5'd12:   p = '{POS_ZERO, POS_NEG,  POS_PLUS};
      5'd13:   p = '{POS_NEG,  POS_PLUS, POS_ZERO};
      5'd14:   p = '{POS_ZERO, POS_PLUS, POS_PLUS};
      5'd15:   p = '{POS_ZERO, POS_PLUS, POS_NEG};
      5'd16:   p = '{POS_PLUS, POS_NEG,  POS_ZERO};
      5'd17:   p = '{POS_PLUS, POS_ZERO, POS_NEG};
      5'd18:   p = '{POS_PLUS, POS_ZERO, POS_PLUS};
      5'd19:   p = '{POS_PLUS, POS_PLUS, POS_ZERO};
      default: p = '{POS_ZERO, POS_ZERO, POS_ZERO};
    endcase
    return p;
  endfunction

endpackage

// ----- sv/hsfe_front.sv -----
// ----------------------------------------------------------------------------
// hsfe_front
// Input stage: accept a point, clamp each coordinate to -1..+1 and hold it
// until the queue takes it.
// ----------------------------------------------------------------------------
module hsfe_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [FRAC_BITS+1:0] csi,
  input  logic signed [FRAC_BITS+1:0] eta,
  input  logic signed [FRAC_BITS+1:0] zeta,
  output logic                       push_valid,
  input  logic                       push_ready,
  output logic [3*(FRAC_BITS+2)-1:0] push_data
);

  localparam int IW = FRAC_BITS + 2;
  localparam logic signed [IW-1:0] ONE  = IW'(1) << FRAC_BITS;
  localparam logic signed [IW-1:0] MONE = -(IW'(1) << FRAC_BITS);

  logic                       valid;
  logic [3*IW-1:0]            point;

  function automatic logic signed [IW-1:0] clamp(input logic signed [IW-1:0] x);
    logic signed [IW-1:0] y;
    priority if (x > ONE) begin
      y = ONE;
    end else if (x < MONE) begin
      y = MONE;
    end else begin
      y = x;
    end
    return y;
  endfunction

  assign in_ready   = !valid || push_ready;
  assign push_valid = valid;
  assign push_data  = point;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // payload: load on every accepted beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      point <= {clamp(zeta), clamp(eta), clamp(csi)};
    end
  end

endmodule

// ----- sv/hsfe_queue.sv -----
// ----------------------------------------------------------------------------
// hsfe_queue
// Two-entry point queue between the input stage and the evaluation pipeline.
// ----------------------------------------------------------------------------
module hsfe_queue #(
  parameter int W = 54
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0]                  mem [hsfe_pkg::QDEPTH];
  logic [hsfe_pkg::QPTR_W-1:0]   wptr;
  logic [hsfe_pkg::QPTR_W-1:0]   rptr;
  logic [hsfe_pkg::QCNT_W-1:0]   count;
  logic                          push;
  logic                          pop;

  assign push_ready = (count != hsfe_pkg::QCNT_W'(hsfe_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + hsfe_pkg::QCNT_W'(push) - hsfe_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

// ----- sv/hsfe_back.sv -----
// ----------------------------------------------------------------------------
// hsfe_back
// Node sequencer and three-multiply evaluation pipeline with output register.
// ----------------------------------------------------------------------------
module hsfe_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  logic [3*(FRAC_BITS+2)-1:0]        pop_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hsfe_pkg::NODE_W-1:0]       node,
  output logic signed [FRAC_BITS+2:0]       shape_value,
  output logic signed [FRAC_BITS+2:0]       deriv_csi,
  output logic signed [FRAC_BITS+2:0]       deriv_eta,
  output logic signed [FRAC_BITS+2:0]       deriv_zeta,
  output logic                              last
);

  localparam int IW   = FRAC_BITS + 2;
  localparam int OUTW = FRAC_BITS + 3;
  localparam int OW   = FRAC_BITS + 5;
  localparam int PW   = 2 * OW;
  localparam int NW   = hsfe_pkg::NODE_W;

  localparam logic signed [OW-1:0] ONE  = OW'(1) << FRAC_BITS;
  localparam logic signed [OW-1:0] TWO  = OW'(1) << (FRAC_BITS + 1);
  localparam logic signed [OW-1:0] OMAX = (OW'(1) << (OUTW - 1)) - OW'(1);
  localparam logic signed [OW-1:0] OMIN = -(OW'(1) << (OUTW - 1));

  typedef struct packed {
    logic [NW-1:0]              node;
    logic                       last;
    logic [OW-1:0]              v_a;
    logic [OW-1:0]              v_b;
    hsfe_pkg::shift_t           v_sh;
    logic                       v_edge;
    logic [OW-1:0]              v_b2;
    logic [OW-1:0]              v_b3;
    logic [2:0][OW-1:0]         d_a;
    logic [2:0][OW-1:0]         d_b;
    logic [2:0][OW-1:0]         d_b2;
    logic [2:0]                 d_useq;
    hsfe_pkg::shift_t [2:0]     d_sh2;
    logic [2:0]                 d_neg;
  } s1_t;

  typedef struct packed {
    logic [NW-1:0]              node;
    logic                       last;
    logic [OW-1:0]              v_r;
    logic [OW-1:0]              v_b2;
    logic [OW-1:0]              v_b3;
    logic [2:0][OW-1:0]         d_r;
    logic [2:0][OW-1:0]         d_b2;
    logic [2:0]                 d_useq;
    hsfe_pkg::shift_t [2:0]     d_sh2;
    logic [2:0]                 d_neg;
  } s2_t;

  typedef struct packed {
    logic [NW-1:0]              node;
    logic                       last;
    logic [OW-1:0]              v_r;
    logic [OW-1:0]              v_b3;
    logic [2:0][OW-1:0]         d_r;
    logic [2:0]                 d_neg;
  } s3_t;

  // a*b / 2^(FRAC_BITS+sh), rounded to nearest, ties away from zero
  function automatic logic signed [OW-1:0] rmul(input logic signed [OW-1:0] a,
                                                input logic signed [OW-1:0] b,
                                                input hsfe_pkg::shift_t sh);
    logic signed [PW-1:0] prod;
    logic [PW-1:0]        mag;
    logic [PW-1:0]        rnd;
    prod = a * b;
    mag  = prod[PW-1] ? $unsigned(-prod) : $unsigned(prod);
    rnd  = (mag + (PW'(1) << (FRAC_BITS - 1 + int'(sh)))) >> (FRAC_BITS + int'(sh));
    return prod[PW-1] ? -OW'(rnd) : OW'(rnd);
  endfunction

  function automatic logic signed [OW-1:0] cmul(input hsfe_pkg::pos_t c,
                                                input logic signed [OW-1:0] x);
    logic signed [OW-1:0] y;
    priority if (c == hsfe_pkg::POS_PLUS) begin
      y = x;
    end else if (c == hsfe_pkg::POS_NEG) begin
      y = -x;
    end else begin
      y = '0;
    end
    return y;
  endfunction

  function automatic logic [OUTW-1:0] sat(input logic signed [OW-1:0] x);
    logic signed [OW-1:0] y;
    priority if (x > OMAX) begin
      y = OMAX;
    end else if (x < OMIN) begin
      y = OMIN;
    end else begin
      y = x;
    end
    return y[OUTW-1:0];
  endfunction

  // sequencer
  logic                 have_pt;
  logic [NW-1:0]        nidx;
  logic [3*IW-1:0]      pt;
  logic                 adv;
  logic                 last_node;

  // pipeline
  logic                 v1;
  logic                 v2;
  logic                 v3;
  s1_t                  s1;
  s1_t                  s1_next;
  s2_t                  s2;
  s2_t                  s2_next;
  s3_t                  s3;
  s3_t                  s3_next;

  // output stage next values
  logic [OUTW-1:0]      shape_next;
  logic [2:0][OUTW-1:0] deriv_next;

  assign adv       = !out_valid || out_ready;
  assign last_node = (nidx == NW'(hsfe_pkg::NODES - 1));
  assign pop_ready = adv && (!have_pt || last_node);

  always_ff @(posedge clk) begin
    if (rst) begin
      have_pt <= 1'b0;
      nidx    <= '0;
    end else if (adv) begin
      if (!have_pt || last_node) begin
        have_pt <= pop_valid;
        nidx    <= '0;
      end else begin
        nidx <= nidx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      pt <= pop_data;
    end
  end

  // node classification and operand setup
  always_comb begin
    hsfe_pkg::node_pos_t   pos;
    logic signed [OW-1:0]  px   [3];
    logic signed [OW-1:0]  cp   [3];
    logic signed [OW-1:0]  fac  [3];
    logic signed [OW-1:0]  sum;
    logic signed [OW-1:0]  tk;
    logic                  corner;
    logic [1:0]            m;
    logic [1:0]            mo1;
    logic [1:0]            mo2;
    logic [1:0]            o1;
    logic [1:0]            o2;
    logic [1:0]            j;

    pos = hsfe_pkg::node_pos(nidx);
    for (int k = 0; k < 3; k++) begin
      px[k]  = OW'($signed(pt[k*IW +: IW]));
      cp[k]  = cmul(pos[k], px[k]);
      fac[k] = ONE + cp[k];
    end
    sum    = cp[0] + cp[1] + cp[2];
    corner = (pos[0] != hsfe_pkg::POS_ZERO) && (pos[1] != hsfe_pkg::POS_ZERO) &&
             (pos[2] != hsfe_pkg::POS_ZERO);
    priority if (pos[0] == hsfe_pkg::POS_ZERO) begin
      m = 2'd0;
    end else if (pos[1] == hsfe_pkg::POS_ZERO) begin
      m = 2'd1;
    end else begin
      m = 2'd2;
    end
    mo1 = (m == 2'd2) ? 2'd0 : m + 2'd1;
    mo2 = (m == 2'd0) ? 2'd2 : m - 2'd1;

    s1_next.node   = nidx;
    s1_next.last   = last_node;
    s1_next.v_a    = corner ? fac[0] : px[m];
    s1_next.v_b    = corner ? fac[1] : px[m];
    s1_next.v_sh   = corner ? hsfe_pkg::SH_F1 : hsfe_pkg::SH_F;
    s1_next.v_edge = !corner;
    s1_next.v_b2   = corner ? fac[2] : fac[mo1];
    s1_next.v_b3   = corner ? (sum - TWO) : fac[mo2];

    for (int k = 0; k < 3; k++) begin
      o1 = (k == 2) ? 2'd0 : 2'(k + 1);
      o2 = (k == 0) ? 2'd2 : 2'(k - 1);
      j  = (m == o1) ? o2 : o1;
      tk = sum + cp[k] - ONE;
      s1_next.d_a[k]    = corner ? fac[o1] : px[k];
      s1_next.d_b[k]    = corner ? fac[o2] : fac[o1];
      s1_next.d_useq[k] = !corner && (m != 2'(k));
      if (corner) begin
        s1_next.d_b2[k]  = tk;
        s1_next.d_sh2[k] = hsfe_pkg::SH_F2;
        s1_next.d_neg[k] = (pos[k] == hsfe_pkg::POS_NEG);
      end else if (m == 2'(k)) begin
        // free axis of an edge node: derivative of (1 - u*u)
        s1_next.d_b2[k]  = fac[o2];
        s1_next.d_sh2[k] = hsfe_pkg::SH_F;
        s1_next.d_neg[k] = 1'b1;
      end else begin
        s1_next.d_b2[k]  = fac[j];
        s1_next.d_sh2[k] = hsfe_pkg::SH_F2;
        s1_next.d_neg[k] = (pos[k] == hsfe_pkg::POS_NEG);
      end
    end
  end

  // first multiply
  always_comb begin
    logic signed [OW-1:0] vr;
    vr = rmul(s1.v_a, s1.v_b, s1.v_sh);
    s2_next.node   = s1.node;
    s2_next.last   = s1.last;
    s2_next.v_r    = s1.v_edge ? (ONE - vr) : vr;
    s2_next.v_b2   = s1.v_b2;
    s2_next.v_b3   = s1.v_b3;
    s2_next.d_b2   = s1.d_b2;
    s2_next.d_useq = s1.d_useq;
    s2_next.d_sh2  = s1.d_sh2;
    s2_next.d_neg  = s1.d_neg;
    for (int k = 0; k < 3; k++) begin
      s2_next.d_r[k] = rmul(s1.d_a[k], s1.d_b[k], hsfe_pkg::SH_F1);
    end
  end

  // second multiply; edge side derivatives take q from the value lane
  always_comb begin
    s3_next.node  = s2.node;
    s3_next.last  = s2.last;
    s3_next.v_r   = rmul(s2.v_r, s2.v_b2, hsfe_pkg::SH_F1);
    s3_next.v_b3  = s2.v_b3;
    s3_next.d_neg = s2.d_neg;
    for (int k = 0; k < 3; k++) begin
      s3_next.d_r[k] = rmul(s2.d_useq[k] ? s2.v_r : s2.d_r[k], s2.d_b2[k],
                            s2.d_sh2[k]);
    end
  end

  // third multiply, sign and saturation
  always_comb begin
    shape_next = sat(rmul(s3.v_r, s3.v_b3, hsfe_pkg::SH_F1));
    for (int k = 0; k < 3; k++) begin
      deriv_next[k] = sat(s3.d_neg[k] ? -s3.d_r[k] : s3.d_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= have_pt;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // payload: advance the whole pipe together
  always_ff @(posedge clk) begin
    if (adv) begin
      s1          <= s1_next;
      s2          <= s2_next;
      s3          <= s3_next;
      node        <= s3.node;
      last        <= s3.last;
      shape_value <= shape_next;
      deriv_csi   <= deriv_next[0];
      deriv_eta   <= deriv_next[1];
      deriv_zeta  <= deriv_next[2];
    end
  end

endmodule

// ----- sv/hex20_shape_function_eval.sv -----
// ----------------------------------------------------------------------------
// hex20_shape_function_eval
// 20-node serendipity hexahedron shape functions and their partial
// derivatives at a reference cube point, one beat per node.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | beat contents
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | csi, eta, zeta (signed, FRAC_BITS frac)
//  out     | out_valid / out_ready| node, shape_value, deriv_csi, deriv_eta,
//          |                      | deriv_zeta, last (set on node 19)
//
// Every input point yields 20 output beats, nodes 0..19 in order, one beat
// per cycle while out_ready is high; the node sequencer takes the next point
// from the queue only as it issues the last node of the current one. Beats
// pass the sequencer register, s1, s2, s3 and the output register.
// Reset clears the valid bits, the queue and the sequencer; data registers
// are not reset.
// out_ready low freezes the whole evaluation pipeline; the input side keeps
// taking points until the two-entry queue and the input register are full.
//
// Arithmetic: coordinates are clamped to -1..+1 on entry. Each product is
// rounded to nearest with ties away from zero and results saturate to the
// output width.
// ----------------------------------------------------------------------------
module hex20_shape_function_eval #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [FRAC_BITS+1:0]   csi,
  input  logic signed [FRAC_BITS+1:0]   eta,
  input  logic signed [FRAC_BITS+1:0]   zeta,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hsfe_pkg::NODE_W-1:0]   node,
  output logic signed [FRAC_BITS+2:0]   shape_value,
  output logic signed [FRAC_BITS+2:0]   deriv_csi,
  output logic signed [FRAC_BITS+2:0]   deriv_eta,
  output logic signed [FRAC_BITS+2:0]   deriv_zeta,
  output logic                          last
);

  localparam int PTW = 3 * (FRAC_BITS + 2);

  // front to queue
  logic           push_valid;
  logic           push_ready;
  logic [PTW-1:0] push_data;

  // queue to back
  logic           pop_valid;
  logic           pop_ready;
  logic [PTW-1:0] pop_data;

  // Front: clamp the coordinates and hold the point for the queue.
  hsfe_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .csi        (csi),
    .eta        (eta),
    .zeta       (zeta),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue: decouple point intake from the 20-beat evaluation.
  hsfe_queue #(
    .W (PTW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: walk the nodes, three rounded multiplies deep, registered output.
  hsfe_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .node        (node),
    .shape_value (shape_value),
    .deriv_csi   (deriv_csi),
    .deriv_eta   (deriv_eta),
    .deriv_zeta  (deriv_zeta),
    .last        (last)
  );

  // last marks exactly the final node of a point
  a_last_on_final_node: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (node == hsfe_pkg::NODE_W'(hsfe_pkg::NODES - 1))))
    else $error("last flag does not match final node");

  // within a point, taken beats are followed by the next node in order
  a_node_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last ##1 out_valid |->
      node == $past(node) + hsfe_pkg::NODE_W'(1))
    else $error("node sequence skipped or repeated");

  // a new point starts at node 0
  a_point_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last ##1 out_valid |-> node == '0)
    else $error("point did not start at node 0");

endmodule
